// ----- rtl/bir_pkg.sv -----
// Shared types and constants for the bimodal insertion replacement block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bir_pkg;

   localparam int SET_W    = 11;
   localparam int WAY_W    = 4;
   localparam int STAMP_W  = 32;
   localparam int RAND_W   = 8;
   localparam int DEF_SETS = 2048;
   localparam int DEF_WAYS = 16;

   // Request operation codes
   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_REDUCE,
      ST_FINISH
   } bir_state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic clear_step;
      logic read;
      logic reduce;
      logic reduce_first;
      logic write_mru;
      logic write_lru;
      logic load_rsp;
   } bir_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic clear_last;
      logic is_update;
      logic set_ok;
      logic way_ok;
      logic mru;
      logic rsp_busy;
   } bir_sts_type;

endpackage

`default_nettype wire

// ----- rtl/bir_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
// Depends on bir_pkg for field widths.
`default_nettype none

interface bir_req_if
   import bir_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               op;
   logic [SET_W-1:0]   set_index;
   logic [WAY_W-1:0]   way_index;
   logic [STAMP_W-1:0] cycle_stamp;
   logic [RAND_W-1:0]  random_value;

   modport source (
      output valid, op, set_index, way_index, cycle_stamp, random_value,
      input  ready
   );
   modport sink (
      input  valid, op, set_index, way_index, cycle_stamp, random_value,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/bir_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the victim way.
// Depends on bir_pkg for field widths.
`default_nettype none

interface bir_rsp_if
   import bir_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [WAY_W-1:0] victim_way;

   modport source (
      output valid, victim_way,
      input  ready
   );
   modport sink (
      input  valid, victim_way,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/bir_ctrl.sv -----
// Sequencer for the replacement block: clearing pass, request dispatch,
// minimum-tree stepping and write-back. Depends on bir_pkg.
`default_nettype none

module bir_ctrl
   import bir_pkg::*;
#(
   parameter int WAYS = DEF_WAYS
) (
   input  logic        clock,
   input  logic        reset,
   input  bir_sts_type sts,
   output bir_cmd_type cmd
);

   localparam int LEVELS = $clog2(WAYS);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   bir_state_type state_ff, state_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          lvl_last;

   assign lvl_last = (lvl_ff == LW'(LEVELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (sts.req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            lvl_in = '0;
            if (sts.is_update && !(sts.set_ok && sts.way_ok)) begin
               state_in = ST_IDLE;
            end else if (sts.is_update && sts.mru) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            lvl_in = lvl_ff + 1'b1;
            if (lvl_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.is_update || !sts.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE:  cmd.req_ready  = 1'b1;
         ST_DECIDE: begin
            cmd.read      = 1'b1;
            cmd.write_mru = sts.is_update && sts.set_ok && sts.way_ok && sts.mru;
         end
         ST_REDUCE: begin
            cmd.reduce       = 1'b1;
            cmd.reduce_first = (lvl_ff == '0);
         end
         ST_FINISH: begin
            cmd.write_lru = sts.is_update;
            cmd.load_rsp  = !sts.is_update && !sts.rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/bir_dp.sv -----
// Datapath: stamp memory, request and register capture, registered
// minimum tree and response register. Depends on bir_pkg and the channels.
`default_nettype none

module bir_dp
   import bir_pkg::*;
#(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   bir_req_if.sink           req_if,
   bir_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic [RAND_W-1:0] csr_wr_data,
   input  bir_cmd_type       cmd,
   output bir_sts_type       sts
);

   localparam int LEVELS = $clog2(WAYS);
   localparam int WP2    = 1 << LEVELS;
   localparam int IW     = LEVELS;
   localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;

   logic [STAMP_W-1:0] stamp_mem_ff [SETS][WAYS];

   logic               op_ff;
   logic [SET_W-1:0]   set_ff;
   logic [WAY_W-1:0]   way_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [RAND_W-1:0]  rand_ff;
   logic [RAND_W-1:0]  num_ff;
   logic [SW-1:0]      clr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WAY_W-1:0]   victim_ff;

   logic [STAMP_W-1:0] row_ff      [WAYS];
   logic [STAMP_W-1:0] cand_val_ff [WP2];
   logic [IW-1:0]      cand_idx_ff [WP2];
   logic [STAMP_W-1:0] cand_val_in [WP2];
   logic [IW-1:0]      cand_idx_in [WP2];
   logic [STAMP_W-1:0] pad_row     [WP2];
   logic [STAMP_W-1:0] src_val     [WP2];
   logic [IW-1:0]      src_idx     [WP2];

   logic                  capture;
   logic [SW+SET_W-1:0]   set_wide;
   logic [SW-1:0]         set_addr;
   logic                  set_ok;
   logic                  wr_any;
   logic [SW-1:0]         wr_addr;
   logic [STAMP_W-1:0]    wr_data;
   logic [WAYS-1:0]       wr_lane;
   logic [STAMP_W-1:0]    min_dec;

   assign capture  = req_if.valid && cmd.req_ready;
   assign req_if.ready = cmd.req_ready;

   assign set_wide = {{SW{1'b0}}, set_ff};
   assign set_addr = set_wide[SW-1:0];
   assign set_ok   = (int'(set_ff) < SETS);

   assign sts.req_valid  = req_if.valid;
   assign sts.clear_last = (clr_ff == SW'(SETS - 1));
   assign sts.is_update  = (op_ff == OP_UPDATE);
   assign sts.set_ok     = set_ok;
   assign sts.way_ok     = (int'(way_ff) < WAYS);
   assign sts.mru        = (rand_ff > num_ff);
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_if.ready;

   // Request word and insertion register
   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff    <= req_if.op;
         set_ff   <= req_if.set_index;
         way_ff   <= req_if.way_index;
         stamp_ff <= req_if.cycle_stamp;
         rand_ff  <= req_if.random_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (csr_wr_en) num_ff <= csr_wr_data;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
      end
   end

   // Write port: whole row while clearing, one way lane otherwise
   assign min_dec = (cand_val_ff[0] == '0) ? '0 : cand_val_ff[0] - STAMP_W'(1);
   assign wr_any  = cmd.write_mru || cmd.write_lru;

   always_comb begin
      wr_addr = cmd.clear_step ? clr_ff : set_addr;
      wr_data = cmd.clear_step ? '0 : (cmd.write_mru ? stamp_ff : min_dec);
      for (int w = 0; w < WAYS; w++) begin
         wr_lane[w] = cmd.clear_step || (wr_any && (int'(way_ff) == w));
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < WAYS; w++) begin
         if (wr_lane[w]) stamp_mem_ff[wr_addr][w] <= wr_data;
      end
   end

   // Registered row read
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         for (int w = 0; w < WAYS; w++) begin
            row_ff[w] <= stamp_mem_ff[set_addr][w];
         end
      end
   end

   // Pad the row to a power of two; padding sits above every real way,
   // so a tie with it keeps the real way
   for (genvar g = 0; g < WP2; g++) begin : g_pad
      if (g < WAYS) begin : g_real
         assign pad_row[g] = row_ff[g];
      end else begin : g_fill
         assign pad_row[g] = '1;
      end
   end

   // One tree level per cycle; the lower index wins a tie
   always_comb begin
      for (int i = 0; i < WP2; i++) begin
         src_val[i] = cmd.reduce_first ? pad_row[i] : cand_val_ff[i];
         src_idx[i] = cmd.reduce_first ? IW'(i) : cand_idx_ff[i];
         cand_val_in[i] = cand_val_ff[i];
         cand_idx_in[i] = cand_idx_ff[i];
      end
      for (int i = 0; i < WP2 / 2; i++) begin
         if (src_val[2*i+1] < src_val[2*i]) begin
            cand_val_in[i] = src_val[2*i+1];
            cand_idx_in[i] = src_idx[2*i+1];
         end else begin
            cand_val_in[i] = src_val[2*i];
            cand_idx_in[i] = src_idx[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         for (int i = 0; i < WP2; i++) begin
            cand_val_ff[i] <= cand_val_in[i];
            cand_idx_ff[i] <= cand_idx_in[i];
         end
      end
   end

   // Response register: hold until taken, reload when the slot frees
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         victim_ff <= set_ok ? WAY_W'(cand_idx_ff[0]) : '0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.victim_way = victim_ff;

endmodule

`default_nettype wire

// ----- rtl/bimodal_insertion_replacement.sv -----
// Bimodal insertion replacement: one 32-bit last-used stamp per way of
// each set, kept in a row-wide memory. After reset a clearing pass writes
// one set row per cycle through all SETS rows before the first request is
// accepted. A victim request goes through one row read, one level of the
// registered minimum tree per cycle, then the response register load, which
// waits while an earlier word is not yet taken. An LRU-inserting update
// takes the same steps, its write-back replacing the response; an
// MRU-inserting update, or one whose set or way is out of range, skips the
// tree as it needs no minimum. One request is in flight at a time; a new one
// is taken while a finished victim word still waits on the response channel.
// Depends on bir_pkg, bir_req_if, bir_rsp_if, bir_ctrl and bir_dp.
`default_nettype none

module bimodal_insertion_replacement
   import bir_pkg::*;
#(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   bir_req_if.sink           req_if,
   bir_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic [RAND_W-1:0] csr_wr_data
);

   bir_cmd_type cmd;
   bir_sts_type sts;

   bir_ctrl #(
      .WAYS (WAYS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   bir_dp #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

`ifndef SYNTHESIS
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> cmd.read)
      else $error("accepted word not followed by a row read");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !sts.rsp_busy)
      else $error("response loaded over a word not yet taken");

   a_lru_write_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.write_lru |-> (sts.is_update && sts.set_ok && sts.way_ok && !sts.mru))
      else $error("LRU write-back for a request that must not write");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !(cmd.write_mru || cmd.write_lru || req_if.ready))
      else $error("request activity during the clearing pass");
`endif

endmodule

`default_nettype wire
